/* hdl/ccfr_pkg.sv */
// ----------------------------------------------------------------------------
// ccfr_pkg
// Shared types, constants and the CRC byte step of the COBS frame receiver.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  localparam logic [7:0]  START_MARKER_RST = 8'h02;
  localparam logic [7:0]  END_MARKER_RST   = 8'h03;

  localparam logic [7:0]  REG_START_MARKER = 8'd0;
  localparam logic [7:0]  REG_END_MARKER   = 8'd1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;
  localparam logic [7:0]  CODE_MAX = 8'hFF;

  // type, seq, len, crc_lo, crc_hi
  localparam int          FRAME_OVERHEAD = 5;
  localparam int          HEADER_BYTES   = 3;

  typedef struct packed {
    logic        last;
    logic [15:0] crc_value;
    logic [7:0]  payload_byte;
    logic [5:0]  byte_index;
    logic [6:0]  payload_length;
    logic [7:0]  sequence_res;
    logic [7:0]  frame_type;
  } result_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* hdl/cobs_crc_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// cobs_crc_frame_receiver_core
// Collects a marker-delimited frame, COBS-decodes it, checks length and
// CRC-16/CCITT-FALSE and emits one result per payload byte, or one for no payload.
// ----------------------------------------------------------------------------
//  channel | ports                          | contents
//  --------+--------------------------------+------------------------------
//  in      | s_tvalid s_tready s_tdata[7:0] | rx_byte
//  out     | m_tvalid m_tready m_tdata m_tlast | see m_tdata, last
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | 0 start, 1 end marker
//
// The end marker starts a decode walk over the raw store: each stored byte is
// read from registered memory (S_RD), then decoded (S_PROC); an inserted zero
// adds an S_ZERO step, and the end of the store leads to the check (S_CHECK).
// Each result is read from the body store (S_ERD), loaded into the output
// register (S_ELD) and held until m_tready (S_EWAIT). s_tready is low for the
// whole walk and emission. Reset clears control state; the stores are not cleared.
// ----------------------------------------------------------------------------
module cobs_crc_frame_receiver_core #(
  parameter int BUFFER_DEPTH = 128,
  parameter int PAYLOAD_MAX  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // frame_type, sequence_res, payload_length,
                                 // byte_index, payload_byte, crc_value, zero fill
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW       = $clog2(BUFFER_DEPTH);
  localparam int BODY_MAX = PAYLOAD_MAX + ccfr_pkg::FRAME_OVERHEAD;
  localparam int BIW      = $clog2(BODY_MAX);
  localparam int BCW      = $clog2(BODY_MAX + 1);

  localparam logic [3:0] S_RX    = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_PROC  = 4'd2;
  localparam logic [3:0] S_ZERO  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_ERD   = 4'd5;
  localparam logic [3:0] S_ELD   = 4'd6;
  localparam logic [3:0] S_EWAIT = 4'd7;

  logic [3:0]    state;
  logic [7:0]    start_marker;
  logic [7:0]    end_marker;
  logic          receiving;
  logic [AW-1:0] raw_count;
  logic [AW-1:0] rd;
  logic [7:0]    left;
  logic          code_ff;
  logic [BCW-1:0] wr;
  logic [15:0]   crc0, crc1, crc2;
  logic [7:0]    byte_prev, byte_last;
  logic [7:0]    hdr_type, hdr_seq, hdr_len;
  logic [5:0]    k;

  logic [7:0]    raw_mem [BUFFER_DEPTH];
  logic [7:0]    raw_q;
  logic [7:0]    body_mem [BODY_MAX];
  logic [7:0]    body_q;

  logic          in_req;
  logic          push;
  logic [7:0]    push_byte;
  logic          body_full;
  logic          more_raw;
  logic [8:0]    len_plus;
  logic          frame_ok;
  logic          res_load;
  ccfr_pkg::result_t res_new;
  ccfr_pkg::result_t res_q;
  logic [BIW-1:0] erd_addr;

  assign s_tready  = (state == S_RX);
  assign cfg_ready = 1'b1;
  assign in_req    = s_tvalid && s_tready;

  assign body_full = (wr >= BCW'(BODY_MAX));
  assign more_raw  = ((rd + AW'(1)) < raw_count);
  assign len_plus  = {1'b0, hdr_len} + 9'(ccfr_pkg::FRAME_OVERHEAD);
  assign frame_ok  = (wr >= BCW'(ccfr_pkg::FRAME_OVERHEAD))
                  && (len_plus == 9'(wr))
                  && (hdr_len <= 8'(PAYLOAD_MAX))
                  && (crc2 == {byte_last, byte_prev});
  assign erd_addr  = BIW'(7'(k) + 7'(ccfr_pkg::HEADER_BYTES));

  always_comb begin
    push      = 1'b0;
    push_byte = 8'h00;
    if (state == S_PROC && left != 8'h00 && !body_full) begin
      push      = 1'b1;
      push_byte = raw_q;
    end else if (state == S_ZERO && !body_full) begin
      push      = 1'b1;
      push_byte = 8'h00;
    end
  end

  always_comb begin
    res_new.frame_type     = hdr_type;
    res_new.sequence_res   = hdr_seq;
    res_new.payload_length = 7'(hdr_len);
    res_new.byte_index     = k;
    res_new.payload_byte   = (hdr_len == 8'h00) ? 8'h00 : body_q;
    res_new.crc_value      = {byte_last, byte_prev};
    res_new.last           = (hdr_len == 8'h00) || ({2'b00, k} + 8'd1 == hdr_len);
  end

  assign res_load = (state == S_ELD);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= ccfr_pkg::START_MARKER_RST;
      end_marker   <= ccfr_pkg::END_MARKER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ccfr_pkg::REG_START_MARKER: start_marker <= cfg_data;
        ccfr_pkg::REG_END_MARKER:   end_marker   <= cfg_data;
        default: ;
      endcase
    end
  end

  // raw store
  always_ff @(posedge clk) begin
    if (in_req && receiving && s_tdata != end_marker
        && raw_count < AW'(BUFFER_DEPTH - 2)) begin
      raw_mem[raw_count] <= s_tdata;
    end
    if (state == S_RD) begin
      raw_q <= raw_mem[rd];
    end
  end

  // decoded body store
  always_ff @(posedge clk) begin
    if (push) begin
      body_mem[wr[BIW-1:0]] <= push_byte;
    end
    if (state == S_ERD) begin
      body_q <= body_mem[erd_addr];
    end
  end

  // running CRC, header and trailer capture
  always_ff @(posedge clk) begin
    if (in_req) begin
      crc0 <= ccfr_pkg::CRC_INIT;
      crc1 <= ccfr_pkg::CRC_INIT;
      crc2 <= ccfr_pkg::CRC_INIT;
    end else if (push) begin
      crc0      <= ccfr_pkg::crc_step(crc0, push_byte);
      crc1      <= crc0;
      crc2      <= crc1;
      byte_prev <= byte_last;
      byte_last <= push_byte;
      if (wr == BCW'(0)) begin
        hdr_type <= push_byte;
      end
      if (wr == BCW'(1)) begin
        hdr_seq <= push_byte;
      end
      if (wr == BCW'(2)) begin
        hdr_len <= push_byte;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RX;
      receiving <= 1'b0;
      raw_count <= '0;
      rd        <= '0;
      wr        <= '0;
      left      <= 8'h00;
      code_ff   <= 1'b0;
      k         <= 6'd0;
    end else begin
      if (push) begin
        wr <= wr + BCW'(1);
      end
      unique case (state)
        S_RX: begin
          if (in_req) begin
            if (!receiving) begin
              if (s_tdata == start_marker) begin
                receiving <= 1'b1;
                raw_count <= '0;
              end
            end else if (s_tdata == end_marker) begin
              if (raw_count != '0) begin
                receiving <= 1'b0;
                rd        <= '0;
                wr        <= '0;
                left      <= 8'h00;
                code_ff   <= 1'b0;
                state     <= S_RD;
              end
            end else if (raw_count >= AW'(BUFFER_DEPTH - 2)) begin
              receiving <= 1'b0;
            end else begin
              raw_count <= raw_count + AW'(1);
            end
          end
        end
        S_RD: begin
          if (rd == raw_count) begin
            state <= (left != 8'h00) ? S_RX : S_CHECK;
          end else begin
            state <= S_PROC;
          end
        end
        S_PROC: begin
          rd <= rd + AW'(1);
          if (left == 8'h00) begin
            if (raw_q == 8'h00) begin
              state <= S_RX;
            end else begin
              code_ff <= (raw_q == ccfr_pkg::CODE_MAX);
              left    <= raw_q - 8'd1;
              state   <= (raw_q == 8'd1 && more_raw) ? S_ZERO : S_RD;
            end
          end else if (body_full) begin
            state <= S_RX;
          end else begin
            left  <= left - 8'd1;
            state <= (left == 8'd1 && !code_ff && more_raw) ? S_ZERO : S_RD;
          end
        end
        S_ZERO: begin
          state <= body_full ? S_RX : S_RD;
        end
        S_CHECK: begin
          k     <= 6'd0;
          state <= frame_ok ? S_ERD : S_RX;
        end
        S_ERD: begin
          state <= S_ELD;
        end
        S_ELD: begin
          state <= S_EWAIT;
        end
        S_EWAIT: begin
          if (m_tvalid && m_tready) begin
            if (m_tlast) begin
              state <= S_RX;
            end else begin
              k     <= k + 6'd1;
              state <= S_ERD;
            end
          end
        end
        default: state <= S_RX;
      endcase
    end
  end

  ccfr_tx_stage u_tx (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res_in    (res_new),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res_out   (res_q)
  );

  assign m_tdata = {3'b000, res_q.crc_value, res_q.payload_byte, res_q.byte_index,
                    res_q.payload_length, res_q.sequence_res, res_q.frame_type};
  assign m_tlast = res_q.last;

  a_no_input_while_emitting: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid |-> !s_tready))
    else $error("input taken while a result is pending");

  a_last_returns_to_rx: assert property (@(posedge clk) disable iff (rst)
    ((m_tvalid && m_tready && m_tlast) |=> (state == S_RX)))
    else $error("sequencer did not return to receive after last result");

  a_body_bound: assert property (@(posedge clk) disable iff (rst)
    (wr <= BCW'(BODY_MAX)))
    else $error("decoded body overran its store");

  a_raw_bound: assert property (@(posedge clk) disable iff (rst)
    (raw_count <= AW'(BUFFER_DEPTH - 2)))
    else $error("raw byte count beyond frame limit");

endmodule

/* hdl/ccfr_tx_stage.sv */
// ----------------------------------------------------------------------------
// ccfr_tx_stage
// Output register of the result stream; holds a result until it is taken.
// ----------------------------------------------------------------------------
module ccfr_tx_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ccfr_pkg::result_t res_in,
  output logic             out_valid,
  input  logic             out_ready,
  output ccfr_pkg::result_t res_out
);

  logic valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

  assign out_valid = valid;

endmodule
